FILE: hdl/rlpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rlpt_pkg;

  typedef struct packed {
    logic        [11:0] beam_index;
    logic        [15:0] range_mm;
    logic        [15:0] platform_angle;
    logic        [15:0] robot_heading;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [23:0] robot_z;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } out_word_t;

  typedef struct packed {
    logic        [15:0] range_mm;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [23:0] robot_z;
  } pass_t;

  typedef enum logic [2:0] {
    CFG_START_ANGLE    = 3'd0,
    CFG_ANGLE_STEP     = 3'd1,
    CFG_RANGE_LIMIT    = 3'd2,
    CFG_BEAMS_PER_SCAN = 3'd3,
    CFG_LEVER_OFFSET   = 3'd4
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int MAX_BEAMS  = 4096;

  localparam int PIPE_STAGES = 17;
  localparam int TRIG_STAGES = 10;

  localparam logic [19:0] START_ANGLE_RST = 20'hD0000;
  localparam logic [15:0] ANGLE_STEP_RST  = 16'd728;
  localparam logic [15:0] RANGE_LIMIT_RST = 16'd5000;
  localparam logic [11:0] BEAMS_RST       = 12'd1080;
  localparam logic [10:0] LEVER_RST       = 11'h7FC;

  localparam logic [32:0] TWO_PI_Q30 = 33'd6746518853;
  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;

  // reciprocals, exact for numerators below 2^31
  localparam int SH_42 = 37;
  localparam int SH_20 = 36;
  localparam int SH_6  = 34;
  localparam int SH_56 = 37;
  localparam int SH_30 = 36;
  localparam int SH_12 = 35;
  localparam logic [31:0] RECIP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [31:0] RECIP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [31:0] RECIP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
  localparam logic [31:0] RECIP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [31:0] RECIP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [31:0] RECIP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  localparam int TAB_FRAC = 24;

  localparam longint LP_TAB [6] = '{
    64'sd16771441, 64'sd439241, -64'sd439493, 64'sd16770701, 64'sd24336, 64'sd160073
  };
  localparam longint PR_TAB [9] = '{
    64'sd16776249, 64'sd103365, 64'sd147508,
    -64'sd102954, 64'sd16776834, -64'sd47130,
    -64'sd147795, 64'sd46222, 64'sd16776501
  };
  localparam longint TR_TAB [3] = '{-64'sd36681, -64'sd2461, 64'sd147243};

  function automatic longint coef(longint v, int c);
    if (c >= TAB_FRAC) begin
      return v;
    end
    return (v + (64'sd1 <<< (TAB_FRAC - 1 - c))) >>> (TAB_FRAC - c);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rlpt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module rlpt_cell (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  wire logic en_next_i,
  output logic      en_o,
  output logic      valid_o
);

  logic valid_q;

  assign en_o    = !valid_q || en_next_i;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rlpt_trig.sv
`timescale 1ns / 1ps
`default_nettype none
module rlpt_trig #(
  parameter int TRIG_BITS = 18
) (
  input  wire logic                                  clk_i,
  input  wire logic [rlpt_pkg::TRIG_STAGES-1:0]      en_i,
  input  wire logic [19:0]                           ang_i,
  output logic signed [TRIG_BITS-1:0]                sin_o,
  output logic signed [TRIG_BITS-1:0]                cos_o
);

  localparam int TSH = 31 - TRIG_BITS;
  localparam logic [31:0] TRND = 32'(64'd1 << (TSH - 1));
  localparam logic [31:0] TMAX = 32'((64'd1 << (TRIG_BITS - 1)) - 64'd1);

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } oct_t;

  oct_t        oct_q [0:8];
  logic [17:0] a_q;
  logic [29:0] x_q  [1:7];
  logic [29:0] x2_q [2:7];
  logic [30:0] s_q  [3:8];
  logic [30:0] c_q  [3:8];

  logic [17:0] r0;
  logic [18:0] a0;
  logic [51:0] xp1;
  logic [59:0] x2p2;
  logic [61:0] sp3, cp3;
  logic [60:0] sp4, cp4;
  logic [62:0] sp5, cp5;
  logic [60:0] sp6, cp6;
  logic [62:0] sp7, cp7;
  logic [60:0] sp8, cp8;
  logic [31:0] sr9, cr9;
  logic [TRIG_BITS-2:0] sm9, cm9, sa9, ca9;
  logic signed [TRIG_BITS-1:0] sn9, cs9;

  // octant fold
  always_comb begin
    r0 = ang_i[17:0];
    a0 = 19'h40000 - {1'b0, r0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      oct_q[0].quad <= ang_i[19:18];
      oct_q[0].swap <= r0 > 18'h20000;
      a_q           <= (r0 > 18'h20000) ? a0[17:0] : r0;
    end
  end

  for (genvar j = 1; j <= 8; j++) begin : g_oct
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        oct_q[j] <= oct_q[j-1];
      end
    end
  end

  // radians in q30
  assign xp1 = 52'(a_q) * 52'(rlpt_pkg::TWO_PI_Q30) + 52'(64'd1 << 19);
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      x_q[1] <= xp1[49:20];
    end
  end

  assign x2p2 = 60'(x_q[1]) * 60'(x_q[1]);
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x2_q[2] <= x2p2[59:30];
      x_q[2]  <= x_q[1];
    end
  end

  assign sp3 = 62'(x2_q[2]) * 62'(rlpt_pkg::RECIP_42);
  assign cp3 = 62'(x2_q[2]) * 62'(rlpt_pkg::RECIP_56);
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s_q[3]  <= 31'(sp3 >> rlpt_pkg::SH_42);
      c_q[3]  <= 31'(cp3 >> rlpt_pkg::SH_56);
      x2_q[3] <= x2_q[2];
      x_q[3]  <= x_q[2];
    end
  end

  assign sp4 = 61'(x2_q[3]) * 61'(rlpt_pkg::Q30_ONE - s_q[3]);
  assign cp4 = 61'(x2_q[3]) * 61'(rlpt_pkg::Q30_ONE - c_q[3]);
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s_q[4]  <= sp4[60:30];
      c_q[4]  <= cp4[60:30];
      x2_q[4] <= x2_q[3];
      x_q[4]  <= x_q[3];
    end
  end

  assign sp5 = 63'(s_q[4]) * 63'(rlpt_pkg::RECIP_20);
  assign cp5 = 63'(c_q[4]) * 63'(rlpt_pkg::RECIP_30);
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s_q[5]  <= 31'(sp5 >> rlpt_pkg::SH_20);
      c_q[5]  <= 31'(cp5 >> rlpt_pkg::SH_30);
      x2_q[5] <= x2_q[4];
      x_q[5]  <= x_q[4];
    end
  end

  assign sp6 = 61'(x2_q[5]) * 61'(rlpt_pkg::Q30_ONE - s_q[5]);
  assign cp6 = 61'(x2_q[5]) * 61'(rlpt_pkg::Q30_ONE - c_q[5]);
  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s_q[6]  <= sp6[60:30];
      c_q[6]  <= cp6[60:30];
      x2_q[6] <= x2_q[5];
      x_q[6]  <= x_q[5];
    end
  end

  assign sp7 = 63'(s_q[6]) * 63'(rlpt_pkg::RECIP_6);
  assign cp7 = 63'(c_q[6]) * 63'(rlpt_pkg::RECIP_12);
  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s_q[7]  <= 31'(sp7 >> rlpt_pkg::SH_6);
      c_q[7]  <= 31'(cp7 >> rlpt_pkg::SH_12);
      x2_q[7] <= x2_q[6];
      x_q[7]  <= x_q[6];
    end
  end

  assign sp8 = 61'(x_q[7]) * 61'(rlpt_pkg::Q30_ONE - s_q[7]);
  assign cp8 = 61'(x2_q[7]) * 61'(rlpt_pkg::Q30_ONE - c_q[7]);
  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      s_q[8] <= sp8[60:30];
      c_q[8] <= rlpt_pkg::Q30_ONE - {1'b0, cp8[60:31]};
    end
  end

  // round, saturate, unfold
  always_comb begin
    sr9 = (32'(s_q[8]) + TRND) >> TSH;
    cr9 = (32'(c_q[8]) + TRND) >> TSH;
    sm9 = (sr9 > TMAX) ? TMAX[TRIG_BITS-2:0] : sr9[TRIG_BITS-2:0];
    cm9 = (cr9 > TMAX) ? TMAX[TRIG_BITS-2:0] : cr9[TRIG_BITS-2:0];
    sa9 = oct_q[8].swap ? cm9 : sm9;
    ca9 = oct_q[8].swap ? sm9 : cm9;
    unique case (oct_q[8].quad)
      2'd0: begin
        sn9 = $signed({1'b0, sa9});
        cs9 = $signed({1'b0, ca9});
      end
      2'd1: begin
        sn9 = $signed({1'b0, ca9});
        cs9 = -$signed({1'b0, sa9});
      end
      2'd2: begin
        sn9 = -$signed({1'b0, sa9});
        cs9 = -$signed({1'b0, ca9});
      end
      default: begin
        sn9 = -$signed({1'b0, ca9});
        cs9 = $signed({1'b0, sa9});
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      sin_o <= sn9;
      cos_o <= cs9;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rotating_lidar_point_transform.sv
`timescale 1ns / 1ps
`default_nettype none
// Turns one range sample per word into a point in the odometry frame. A new word can be taken
// every cycle while in_stall_o is low; a kept word passes through the stages in order (one input
// stage, ten stages of the sine and cosine pipeline run for the beam, platform and heading angles
// side by side, then six stages of fixed-point rotation and translation, the last of which is the
// output register). Dropped samples (range above the limit, beam index at or past the scan length)
// give no result. Each stage holds its word until the next stage frees, so a stalled output only
// backs up the pipeline as far as it is full. Config writes belong to idle periods.
module rotating_lidar_point_transform #(
  parameter int COEF_FRAC_BITS = 17,
  parameter int TRIG_BITS      = 18
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rlpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [rlpt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire rlpt_pkg::in_word_t                  in_word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output rlpt_pkg::out_word_t                      out_word_o
);

  localparam int NST = rlpt_pkg::PIPE_STAGES;
  localparam int TS  = TRIG_BITS - 1;
  localparam int C   = COEF_FRAC_BITS;
  localparam int CW  = COEF_FRAC_BITS + 2;
  localparam int LW  = 26;
  localparam int RW  = 26;
  localparam int WW  = 27;
  localparam int YW  = 28;
  localparam int BW  = 30;
  localparam int EW  = 31;
  localparam int FW  = 34;
  localparam int P1W = TRIG_BITS + 18;
  localparam int P2W = LW + CW + 2;
  localparam int P3W = WW + TRIG_BITS + 2;
  localparam int P4W = YW + CW + 3;
  localparam int P5W = BW + TRIG_BITS + 2;

  localparam logic signed [P1W-1:0] RND1 = P1W'(64'sd1 <<< (TS - 9));
  localparam logic signed [P2W-1:0] RND2 = P2W'(64'sd1 <<< (C - 1));
  localparam logic signed [P3W-1:0] RND3 = P3W'(64'sd1 <<< (TS - 1));
  localparam logic signed [P4W-1:0] RND4 = P4W'(64'sd1 <<< (C - 1));
  localparam logic signed [P5W-1:0] RND5 = P5W'(64'sd1 <<< (TS - 1));

  localparam logic signed [CW-1:0] LK0 = CW'(rlpt_pkg::coef(rlpt_pkg::LP_TAB[0], C));
  localparam logic signed [CW-1:0] LK1 = CW'(rlpt_pkg::coef(rlpt_pkg::LP_TAB[1], C));
  localparam logic signed [CW-1:0] LK2 = CW'(rlpt_pkg::coef(rlpt_pkg::LP_TAB[2], C));
  localparam logic signed [CW-1:0] LK3 = CW'(rlpt_pkg::coef(rlpt_pkg::LP_TAB[3], C));
  localparam logic signed [CW-1:0] LK4 = CW'(rlpt_pkg::coef(rlpt_pkg::LP_TAB[4], C));
  localparam logic signed [CW-1:0] LK5 = CW'(rlpt_pkg::coef(rlpt_pkg::LP_TAB[5], C));
  localparam logic signed [CW-1:0] PK0 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[0], C));
  localparam logic signed [CW-1:0] PK1 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[1], C));
  localparam logic signed [CW-1:0] PK2 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[2], C));
  localparam logic signed [CW-1:0] PK3 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[3], C));
  localparam logic signed [CW-1:0] PK4 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[4], C));
  localparam logic signed [CW-1:0] PK5 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[5], C));
  localparam logic signed [CW-1:0] PK6 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[6], C));
  localparam logic signed [CW-1:0] PK7 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[7], C));
  localparam logic signed [CW-1:0] PK8 = CW'(rlpt_pkg::coef(rlpt_pkg::PR_TAB[8], C));
  localparam logic signed [BW-1:0] TR0 = BW'(rlpt_pkg::TR_TAB[0]);
  localparam logic signed [BW-1:0] TR1 = BW'(rlpt_pkg::TR_TAB[1]);
  localparam logic signed [BW-1:0] TR2 = BW'(rlpt_pkg::TR_TAB[2]);

  // config registers
  logic        [19:0] start_q;
  logic        [15:0] step_q;
  logic        [15:0] limit_q;
  logic        [11:0] beams_q;
  logic signed [10:0] lever_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= rlpt_pkg::START_ANGLE_RST;
      step_q  <= rlpt_pkg::ANGLE_STEP_RST;
      limit_q <= rlpt_pkg::RANGE_LIMIT_RST;
      beams_q <= rlpt_pkg::BEAMS_RST;
      lever_q <= $signed(rlpt_pkg::LEVER_RST);
    end else if (cfg_we_i) begin
      unique case (rlpt_pkg::cfg_idx_e'(cfg_idx_i))
        rlpt_pkg::CFG_START_ANGLE:    start_q <= cfg_wdata_i[19:0];
        rlpt_pkg::CFG_ANGLE_STEP:     step_q  <= cfg_wdata_i[15:0];
        rlpt_pkg::CFG_RANGE_LIMIT:    limit_q <= cfg_wdata_i[15:0];
        rlpt_pkg::CFG_BEAMS_PER_SCAN: beams_q <= cfg_wdata_i[11:0];
        rlpt_pkg::CFG_LEVER_OFFSET:   lever_q <= $signed(cfg_wdata_i[10:0]);
        default: ;
      endcase
    end
  end

  // flow control chain
  logic [NST-1:0] v, en;
  logic           keep;

  assign keep = !(in_word_i.range_mm > limit_q) && (in_word_i.beam_index < beams_q)
             && (32'(in_word_i.beam_index) < rlpt_pkg::MAX_BEAMS);

  for (genvar k = 0; k < NST; k++) begin : g_cell
    logic vin, enn;
    if (k == 0) begin : g_first
      assign vin = in_valid_i && keep;
    end else begin : g_mid
      assign vin = v[k-1];
    end
    if (k == NST - 1) begin : g_last
      assign enn = !out_stall_i;
    end else begin : g_next
      assign enn = en[k+1];
    end
    rlpt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .valid_i   (vin),
      .en_next_i (enn),
      .en_o      (en[k]),
      .valid_o   (v[k])
    );
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v[NST-1];

  // input stage
  logic [19:0] theta_q, pa_q, hd_q;
  logic [27:0] beam_off;
  rlpt_pkg::pass_t pass_q [0:15];

  assign beam_off = 28'(in_word_i.beam_index) * 28'(step_q);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      theta_q           <= start_q + beam_off[19:0];
      pa_q              <= {in_word_i.platform_angle, 4'h0};
      hd_q              <= {in_word_i.robot_heading, 4'h0};
      pass_q[0].range_mm <= in_word_i.range_mm;
      pass_q[0].robot_x  <= in_word_i.robot_x;
      pass_q[0].robot_y  <= in_word_i.robot_y;
      pass_q[0].robot_z  <= in_word_i.robot_z;
    end
  end

  for (genvar k = 1; k <= 15; k++) begin : g_pass
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        pass_q[k] <= pass_q[k-1];
      end
    end
  end

  // sine and cosine, stages 1 to 10
  logic signed [TRIG_BITS-1:0] sb, cb, sp10, cp10, sh10, ch10;

  rlpt_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_beam (
    .clk_i (clk_i), .en_i (en[10:1]), .ang_i (theta_q), .sin_o (sb), .cos_o (cb)
  );
  rlpt_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_plat (
    .clk_i (clk_i), .en_i (en[10:1]), .ang_i (pa_q), .sin_o (sp10), .cos_o (cp10)
  );
  rlpt_trig #(.TRIG_BITS(TRIG_BITS)) u_trig_head (
    .clk_i (clk_i), .en_i (en[10:1]), .ang_i (hd_q), .sin_o (sh10), .cos_o (ch10)
  );

  // stage 11: polar to cartesian
  logic signed [P1W-1:0] lxp, lyp;
  logic signed [LW-1:0]  lx_q, ly_q;
  logic signed [TRIG_BITS-1:0] sp11_q, cp11_q, sh11_q, ch11_q;

  assign lxp = $signed({1'b0, pass_q[10].range_mm}) * cb + RND1;
  assign lyp = $signed({1'b0, pass_q[10].range_mm}) * sb + RND1;

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      lx_q   <= LW'(lxp >>> (TS - 8));
      ly_q   <= LW'(lyp >>> (TS - 8));
      sp11_q <= sp10;
      cp11_q <= cp10;
      sh11_q <= sh10;
      ch11_q <= ch10;
    end
  end

  // stage 12: laser to platform
  logic signed [P2W-1:0] rxp, ryp, rzp;
  logic signed [RW-1:0]  rx_q, ry_q, rz_q;
  logic signed [TRIG_BITS-1:0] sp12_q, cp12_q, sh12_q, ch12_q;

  assign rxp = LK0 * lx_q + LK1 * ly_q + RND2;
  assign ryp = LK2 * lx_q + LK3 * ly_q + RND2;
  assign rzp = LK4 * lx_q + LK5 * ly_q + RND2;

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      rx_q   <= RW'(rxp >>> C);
      ry_q   <= RW'(ryp >>> C);
      rz_q   <= RW'(rzp >>> C);
      sp12_q <= sp11_q;
      cp12_q <= cp11_q;
      sh12_q <= sh11_q;
      ch12_q <= ch11_q;
    end
  end

  // stage 13: platform rotation with lever offset
  logic signed [WW-1:0]  w13;
  logic signed [P3W-1:0] yxp, yyp;
  logic signed [YW-1:0]  yx_q, yy_q, yz_q;
  logic signed [TRIG_BITS-1:0] sh13_q, ch13_q;

  assign w13 = WW'(rz_q) + (WW'(lever_q) <<< 8);
  assign yxp = w13 * sp12_q - ry_q * cp12_q + RND3;
  assign yyp = -(ry_q * sp12_q) - w13 * cp12_q + RND3;

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      yx_q   <= YW'(yxp >>> TS);
      yy_q   <= YW'(yyp >>> TS);
      yz_q   <= YW'(rx_q);
      sh13_q <= sh12_q;
      ch13_q <= ch12_q;
    end
  end

  // stage 14: platform to robot
  logic signed [P4W-1:0] bxp, byp, bzp;
  logic signed [BW-1:0]  bx_q, by_q, bz_q;
  logic signed [TRIG_BITS-1:0] sh14_q, ch14_q;

  assign bxp = PK0 * yx_q + PK1 * yy_q + PK2 * yz_q + RND4;
  assign byp = PK3 * yx_q + PK4 * yy_q + PK5 * yz_q + RND4;
  assign bzp = PK6 * yx_q + PK7 * yy_q + PK8 * yz_q + RND4;

  always_ff @(posedge clk_i) begin
    if (en[14]) begin
      bx_q   <= BW'(bxp >>> C) + TR0;
      by_q   <= BW'(byp >>> C) + TR1;
      bz_q   <= BW'(bzp >>> C) + TR2;
      sh14_q <= sh13_q;
      ch14_q <= ch13_q;
    end
  end

  // stage 15: yaw
  logic signed [P5W-1:0] exp15, eyp15;
  logic signed [EW-1:0]  ex_q, ey_q, ez_q;

  assign exp15 = bx_q * ch14_q - by_q * sh14_q + RND5;
  assign eyp15 = bx_q * sh14_q + by_q * ch14_q + RND5;

  always_ff @(posedge clk_i) begin
    if (en[15]) begin
      ex_q <= EW'(exp15 >>> TS);
      ey_q <= EW'(eyp15 >>> TS);
      ez_q <= EW'(bz_q);
    end
  end

  // stage 16: pose translation, round and saturate
  function automatic logic signed [23:0] round_sat(logic signed [FW-1:0] v);
    logic signed [FW-1:0] r;
    r = (v + FW'(64'sd128)) >>> 8;
    if (r > FW'(64'sd8388607)) begin
      return 24'sh7FFFFF;
    end else if (r < FW'(-64'sd8388608)) begin
      return 24'sh800000;
    end
    return r[23:0];
  endfunction

  logic signed [FW-1:0] fx, fy, fz;
  rlpt_pkg::out_word_t  out_q;

  assign fx = FW'(ex_q) + (FW'(pass_q[15].robot_x) <<< 8);
  assign fy = FW'(ey_q) + (FW'(pass_q[15].robot_y) <<< 8);
  assign fz = FW'(ez_q) + (FW'(pass_q[15].robot_z) <<< 8);

  always_ff @(posedge clk_i) begin
    if (en[16]) begin
      out_q.point_x <= round_sat(fx);
      out_q.point_y <= round_sat(fy);
      out_q.point_z <= round_sat(fz);
    end
  end

  assign out_word_o = out_q;

endmodule
`default_nettype wire

FILE: hdl/rlpt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
module rlpt_chk (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire rlpt_pkg::out_word_t out_word_o
);

  // the pipeline only refuses words when its output is full and held
  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled with empty output");

  a_stall_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i) else $error("input stalled while output drains");

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output word dropped");

  a_out_word_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o)) else $error("stalled word changed");

endmodule

bind rotating_lidar_point_transform rlpt_chk u_rlpt_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire

FILE: tb/rotating_lidar_point_transform_tb.sv
`timescale 1ns / 1ps
module rotating_lidar_point_transform_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rlpt_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [rlpt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  rlpt_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rlpt_pkg::out_word_t out_word;

  rotating_lidar_point_transform uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the registers
  logic [19:0] p_start = rlpt_pkg::START_ANGLE_RST;
  logic [15:0] p_step = rlpt_pkg::ANGLE_STEP_RST;
  logic [15:0] p_limit = rlpt_pkg::RANGE_LIMIT_RST;
  logic [11:0] p_beams = rlpt_pkg::BEAMS_RST;
  longint p_lever = -4;

  localparam longint LASER_ROT [6] = '{16771441, 439241, -439493, 16770701, 24336, 160073};
  localparam longint MOUNT_ROT [9] = '{16776249, 103365, 147508, -102954, 16776834, -47130,
                                       -147795, 46222, 16776501};
  localparam longint MOUNT_OFS [3] = '{-36681, -2461, 147243};
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  rlpt_pkg::out_word_t point_q[$];
  int errors = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qcoef(longint v);
    return round_shift(v, 7);
  endfunction

  function automatic longint unsigned trig_mag(longint unsigned v);
    longint unsigned m;
    m = (v + 64'd4096) >> 13;
    return (m > 64'd131071) ? 64'd131071 : m;
  endfunction

  task automatic sin_cos(input logic [19:0] ang, output longint s, output longint c);
    logic [1:0] q;
    longint unsigned r, a, x, x2, t, sv, cv;
    longint sm, cm, tmp;
    bit swap;
    q = ang[19:18];
    r = ang[17:0];
    swap = r > 64'h20000;
    a = swap ? (64'h40000 - r) : r;
    x = (a * 64'd6746518853 + (64'd1 << 19)) >> 20;
    x2 = (x * x) >> 30;
    t = ONE_Q30 - x2 / 42;
    t = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t = ONE_Q30 - ((x2 * t) >> 30) / 6;
    sv = (x * t) >> 30;
    t = ONE_Q30 - x2 / 56;
    t = ONE_Q30 - ((x2 * t) >> 30) / 30;
    t = ONE_Q30 - ((x2 * t) >> 30) / 12;
    cv = ONE_Q30 - ((x2 * t) >> 30) / 2;
    sm = longint'(trig_mag(sv));
    cm = longint'(trig_mag(cv));
    if (swap) begin
      tmp = sm; sm = cm; cm = tmp;
    end
    case (q)
      2'd0: begin s = sm; c = cm; end
      2'd1: begin s = cm; c = -sm; end
      2'd2: begin s = -sm; c = -cm; end
      default: begin s = -cm; c = sm; end
    endcase
  endtask

  function automatic logic signed [23:0] sat_mm(longint q8);
    longint v;
    v = round_shift(q8, 8);
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return 24'(v);
  endfunction

  task automatic transform_point(input rlpt_pkg::in_word_t w, output bit keep,
                                 output rlpt_pkg::out_word_t p);
    logic [39:0] th;
    longint rg, sb, cb, sp, cp, sh, ch, lx, ly, rx, ry, rz, wz, yx, yy, yz, bx, by, bz, ex, ey;
    keep = !(w.range_mm > p_limit || w.beam_index >= p_beams);
    p = '0;
    if (keep) begin
      th = 40'(p_start) + 40'(w.beam_index) * 40'(p_step);
      sin_cos(th[19:0], sb, cb);
      sin_cos({w.platform_angle, 4'b0}, sp, cp);
      sin_cos({w.robot_heading, 4'b0}, sh, ch);
      rg = longint'({48'b0, w.range_mm});
      lx = round_shift(rg * cb, 9);
      ly = round_shift(rg * sb, 9);
      rx = round_shift(qcoef(LASER_ROT[0]) * lx + qcoef(LASER_ROT[1]) * ly, 17);
      ry = round_shift(qcoef(LASER_ROT[2]) * lx + qcoef(LASER_ROT[3]) * ly, 17);
      rz = round_shift(qcoef(LASER_ROT[4]) * lx + qcoef(LASER_ROT[5]) * ly, 17);
      wz = rz + p_lever * 256;
      yx = round_shift(-ry * cp + wz * sp, 17);
      yy = round_shift(-ry * sp - wz * cp, 17);
      yz = rx;
      bx = round_shift(qcoef(MOUNT_ROT[0]) * yx + qcoef(MOUNT_ROT[1]) * yy
                       + qcoef(MOUNT_ROT[2]) * yz, 17) + MOUNT_OFS[0];
      by = round_shift(qcoef(MOUNT_ROT[3]) * yx + qcoef(MOUNT_ROT[4]) * yy
                       + qcoef(MOUNT_ROT[5]) * yz, 17) + MOUNT_OFS[1];
      bz = round_shift(qcoef(MOUNT_ROT[6]) * yx + qcoef(MOUNT_ROT[7]) * yy
                       + qcoef(MOUNT_ROT[8]) * yz, 17) + MOUNT_OFS[2];
      ex = round_shift(bx * ch - by * sh, 17);
      ey = round_shift(bx * sh + by * ch, 17);
      p.point_x = sat_mm(ex + longint'(w.robot_x) * 256);
      p.point_y = sat_mm(ey + longint'(w.robot_y) * 256);
      p.point_z = sat_mm(bz + longint'(w.robot_z) * 256);
    end
  endtask

  task automatic report_error(input string msg);
    $display("error at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // result checker
  always begin : check_points
    logic v, st;
    rlpt_pkg::out_word_t got, want;
    @(negedge clk);
    v = out_valid;
    st = out_stall;
    got = out_word;
    @(posedge clk);
    if (rst_n && v && !st) begin
      if (point_q.size() == 0) begin
        report_error("unexpected point");
      end else begin
        want = point_q.pop_front();
        if (got.point_x !== want.point_x)
          report_error($sformatf("point_x %0d want %0d", got.point_x, want.point_x));
        if (got.point_y !== want.point_y)
          report_error($sformatf("point_y %0d want %0d", got.point_y, want.point_y));
        if (got.point_z !== want.point_z)
          report_error($sformatf("point_z %0d want %0d", got.point_z, want.point_z));
      end
    end
  end

  // receiver stall pattern, with a long hold on request
  always begin : stall_gen
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_word(input rlpt_pkg::in_word_t w);
    int gap;
    logic st;
    bit keep;
    rlpt_pkg::out_word_t p;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
      st = in_stall;
      @(posedge clk);
    end while (st);
    transform_point(w, keep, p);
    if (keep) point_q.insert(point_q.size(), p);
    burst_left--;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rlpt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rlpt_pkg::CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rlpt_pkg::CFG_START_ANGLE: p_start = d;
      rlpt_pkg::CFG_ANGLE_STEP: p_step = d[15:0];
      rlpt_pkg::CFG_RANGE_LIMIT: p_limit = d[15:0];
      rlpt_pkg::CFG_BEAMS_PER_SCAN: p_beams = d[11:0];
      rlpt_pkg::CFG_LEVER_OFFSET: p_lever = longint'($signed(d[10:0]));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(input logic [19:0] st, input logic [15:0] sp, input logic [15:0] lim,
                         input logic [11:0] nb, input logic [10:0] lv);
    drain();
    write_reg(rlpt_pkg::CFG_START_ANGLE, st);
    write_reg(rlpt_pkg::CFG_ANGLE_STEP, 20'(sp));
    write_reg(rlpt_pkg::CFG_RANGE_LIMIT, 20'(lim));
    write_reg(rlpt_pkg::CFG_BEAMS_PER_SCAN, 20'(nb));
    write_reg(rlpt_pkg::CFG_LEVER_OFFSET, {9'($urandom_range(0, 511)), lv});
  endtask

  function automatic rlpt_pkg::in_word_t rand_word();
    rlpt_pkg::in_word_t w;
    w.beam_index = ($urandom_range(0, 9) < 8 && p_beams != 0) ?
                   12'($urandom_range(0, p_beams - 1)) : 12'($urandom);
    w.range_mm = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, p_limit)) : 16'($urandom);
    w.platform_angle = 16'($urandom);
    w.robot_heading = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      w.robot_x = 24'($urandom);
      w.robot_y = 24'($urandom);
      w.robot_z = 24'($urandom);
    end else begin
      w.robot_x = 24'($signed(17'($urandom)));
      w.robot_y = 24'($signed(17'($urandom)));
      w.robot_z = 24'($signed(17'($urandom)));
    end
    return w;
  endfunction

  function automatic rlpt_pkg::in_word_t make_word(input logic [11:0] bi, input logic [15:0] rg,
                                                   input logic [15:0] pa, input logic [15:0] hd,
                                                   input logic [23:0] x, input logic [23:0] y,
                                                   input logic [23:0] z);
    rlpt_pkg::in_word_t w;
    w.beam_index = bi; w.range_mm = rg; w.platform_angle = pa; w.robot_heading = hd;
    w.robot_x = x; w.robot_y = y; w.robot_z = z;
    return w;
  endfunction

  task automatic test_directed;
    send_word(make_word(0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(12'(p_beams - 12'd1), p_limit, 16'h4000, 16'h8000, 24'd1000,
                        -24'sd1000, 0));
    send_word(make_word(5, 16'(p_limit + 16'd1), 0, 0, 0, 0, 0));
    send_word(make_word(p_beams, 100, 0, 0, 0, 0, 0));
    send_word(make_word(12'hFFF, 100, 0, 0, 0, 0, 0));
    send_word(make_word(540, 4000, 16'h2000, 16'h2000, 0, 0, 0));
    send_word(make_word(540, 4000, 16'h2001, 16'h1FFF, 0, 0, 0));
    send_word(make_word(540, 4000, 16'hC000, 16'hFFFF, 0, 0, 0));
    send_word(make_word(270, 5000, 16'hFFFF, 16'h6000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    send_word(make_word(810, 5000, 16'h8000, 16'hA000, 24'h800000, 24'h800000, 24'h800000));
    send_word(make_word(1, 1, 16'h0001, 16'h0001, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_word(make_word(1079, 65535, 0, 0, 0, 0, 0));
    send_word(make_word(12'hAAA, 16'h5555, 16'hAAAA, 16'h5555, 24'hAAAAAA, 24'h555555, 0));
    send_word(make_word(12'h555, 16'h0AAA, 16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA, 0));
    drain();
  endtask

  task automatic test_random(input int n);
    repeat (n) send_word(rand_word());
    drain();
  endtask

  task automatic test_extremes;
    set_all(20'h80000, 16'hFFFF, 16'hFFFF, 12'hFFF, 11'd1000);
    send_word(make_word(12'hFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'h7FFFFF, 24'h800000, 0));
    send_word(make_word(12'hFFF, 16'hFFFF, 0, 0, 0, 0, 0));
    test_random(80);
    set_all(20'h7FFFF, 16'h0000, 16'h0000, 12'd1, -11'sd1000);
    send_word(make_word(0, 0, 16'h1234, 16'h4321, 0, 0, 0));
    test_random(40);
    set_all(20'h00000, 16'd1, 16'd2000, 12'd0, 11'h400);
    test_random(20);
    set_all(20'($urandom), 16'($urandom), 16'($urandom_range(100, 65535)),
            12'($urandom_range(16, 4095)), 11'h3FF);
    test_random(100);
  endtask

  task automatic test_unused_index;
    drain();
    write_reg(3'd5, 20'hFFFFF);
    write_reg(3'd6, 20'd0);
    write_reg(3'd7, 20'h12345);
    test_random(30);
  endtask

  task automatic test_backpressure;
    drain();
    hold_req = 1'b1;
    burst_left = 1000;
    repeat (60) send_word(rand_word());
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200);
    test_extremes();
    test_unused_index();
    test_backpressure();
    set_all(rlpt_pkg::START_ANGLE_RST, rlpt_pkg::ANGLE_STEP_RST, rlpt_pkg::RANGE_LIMIT_RST,
            rlpt_pkg::BEAMS_RST, rlpt_pkg::LEVER_RST);
    test_random(100);
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("simulation failed");
    $finish;
  end

endmodule
